### hw/rtl/sbs_pkg.sv
// Package for the binomial series square root core: types, formats and defaults.
package sbs_pkg;

    // Field widths
    localparam int X_W     = 17;
    localparam int D_W     = 18;
    localparam int TC_W    = 6;
    localparam int INDEX_W = 5;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 64;

    // Defaults
    localparam int                MAX_TERMS_DEF    = 32;
    localparam logic [TC_W-1:0]   TERM_COUNT_RESET = 6'd5;

    // 1.0 in Q2.30 and in Q2.16
    localparam longint            ONE_Q30     = 64'sd1073741824;
    localparam logic [VAL_W-1:0]  ONE_Q30_VAL = 32'h4000_0000;
    localparam logic [D_W-1:0]    ONE_Q16     = 18'h1_0000;

    // Saturation limits
    localparam logic [VAL_W-1:0]  SAT_POS = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  SAT_NEG = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_MUL_G,
        S_MUL_F,
        S_SUM
    } t_state;

endpackage

### hw/rtl/sqrt_binomial_series_core.sv
// Binomial series square root core with one shared multiplier under a small sequencer.
//
//  Channel  | Ports                                               | Transfer
//  ---------+-----------------------------------------------------+---------------------------
//  argument | start, busy, i_x_value                              | start high and busy low
//  result   | o_valid, o_term_index, o_term_value,                | o_valid high, one cycle,
//           | o_partial_sum, o_last                               | receiver cannot stall
//  config   | i_cfg_we, i_cfg_data                                | i_cfg_we high
//
// Term 0 appears the cycle after the argument transfer. Each later term passes through
// coefficient fetch, two passes through the one 32x32 multiplier and shift/saturate/sum,
// and busy stays high while the later terms are worked out; with n equal to one
// the next argument may follow in the next cycle.
// Reset is synchronous, active low, and sets the term count to 5.
// Results are never held back: each is flagged by o_valid for exactly one cycle.
module sqrt_binomial_series_core
    import sbs_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [X_W-1:0]          i_x_value,
    input  logic                    i_cfg_we,
    input  logic [TC_W-1:0]         i_cfg_data,
    output logic                    o_valid,
    output logic [INDEX_W-1:0]      o_term_index,
    output logic signed [VAL_W-1:0] o_term_value,
    output logic signed [VAL_W-1:0] o_partial_sum,
    output logic                    o_last
);

    localparam int IDX_W = (MAX_TERMS > 2) ? $clog2(MAX_TERMS) : 1;

    t_state                  r_state;
    t_state                  n_state;
    logic [TC_W-1:0]         r_term_count;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_last_idx;
    logic signed [D_W-1:0]   r_d;
    logic signed [VAL_W-1:0] r_coef;
    logic signed [VAL_W-1:0] r_g;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0] r_term;
    logic signed [VAL_W-1:0] r_sum;

    logic                    w_accept;
    logic [6:0]              w_tc7;
    logic [6:0]              w_n7;
    logic [6:0]              w_last7;
    logic [6:0]              w_idx7;
    logic signed [VAL_W-1:0] w_coef_tab [MAX_TERMS];
    logic signed [VAL_W-1:0] w_mul_a;
    logic signed [VAL_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [VAL_W-1:0] w_term;
    logic signed [VAL_W:0]   w_sum33;
    logic signed [VAL_W-1:0] w_sum;
    logic                    w_is_last;

    // Coefficient table c_i = (3 - 2i) / (2i) in Q2.30, truncated toward zero
    for (genvar gi = 0; gi < MAX_TERMS; gi++) begin : g_coef
        if (gi == 0) begin : g_zero
            assign w_coef_tab[gi] = '0;
        end else begin : g_val
            localparam longint CoefVal =
                ((longint'(3) - longint'(2 * gi)) * ONE_Q30) / longint'(2 * gi);
            assign w_coef_tab[gi] = 32'(CoefVal);
        end
    end

    assign w_accept = start && !busy;

    // Clamp the term count to 1 .. MAX_TERMS
    assign w_tc7   = {1'b0, r_term_count};
    always_comb begin
        if (w_tc7 == 7'd0) begin
            w_n7 = 7'd1;
        end else if (w_tc7 > 7'(MAX_TERMS)) begin
            w_n7 = 7'(MAX_TERMS);
        end else begin
            w_n7 = w_tc7;
        end
    end
    assign w_last7 = w_n7 - 7'd1;
    assign w_idx7  = 7'(r_idx);
    assign w_is_last = (r_idx == r_last_idx);

    // Shared multiplier: coefficient times offset, then term times factor
    always_comb begin
        if (r_state == S_MUL_F) begin
            w_mul_a = r_term;
            w_mul_b = r_g;
        end else begin
            w_mul_a = r_coef;
            w_mul_b = {{(VAL_W-D_W){r_d[D_W-1]}}, r_d};
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Floor shift by 30 and saturate the new term, then saturating sum
    assign w_shift = r_prod >>> 30;
    always_comb begin
        if (w_shift[PROD_W-1:VAL_W-1] == '0 || w_shift[PROD_W-1:VAL_W-1] == '1) begin
            w_term = w_shift[VAL_W-1:0];
        end else if (w_shift[PROD_W-1]) begin
            w_term = SAT_NEG;
        end else begin
            w_term = SAT_POS;
        end
    end
    assign w_sum33 = {r_sum[VAL_W-1], r_sum} + {w_term[VAL_W-1], w_term};
    always_comb begin
        if (w_sum33[VAL_W] == w_sum33[VAL_W-1]) begin
            w_sum = w_sum33[VAL_W-1:0];
        end else if (w_sum33[VAL_W]) begin
            w_sum = SAT_NEG;
        end else begin
            w_sum = SAT_POS;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && w_n7 != 7'd1) begin
                    n_state = S_COEF;
                end
            end
            S_COEF:  n_state = S_MUL_G;
            S_MUL_G: n_state = S_MUL_F;
            S_MUL_F: n_state = S_SUM;
            S_SUM:   n_state = w_is_last ? S_IDLE : S_COEF;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        busy = (r_state != S_IDLE);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_COUNT_RESET;
            o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_term_count <= i_cfg_data;
            end
            o_valid <= w_accept || (r_state == S_SUM);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_d           <= D_W'({1'b0, i_x_value}) - ONE_Q16;
                    r_term        <= ONE_Q30_VAL;
                    r_sum         <= ONE_Q30_VAL;
                    r_idx         <= IDX_W'(1);
                    r_last_idx    <= w_last7[IDX_W-1:0];
                    o_term_index  <= '0;
                    o_term_value  <= ONE_Q30_VAL;
                    o_partial_sum <= ONE_Q30_VAL;
                    o_last        <= (w_n7 == 7'd1);
                end
            end
            S_COEF: begin
                r_coef <= w_coef_tab[r_idx];
            end
            S_MUL_G: begin
                r_g <= w_prod[47:16];
            end
            S_MUL_F: begin
                r_prod <= w_prod;
            end
            S_SUM: begin
                r_term        <= w_term;
                r_sum         <= w_sum;
                r_idx         <= r_idx + IDX_W'(1);
                o_term_index  <= w_idx7[INDEX_W-1:0];
                o_term_value  <= w_term;
                o_partial_sum <= w_sum;
                o_last        <= w_is_last;
            end
            default: begin
            end
        endcase
    end

    // The final term always hands control back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == S_IDLE))
        else $error("last term emitted while sequencer still running");

    // An argument transfer yields term 0 equal to 1.0 in the next cycle
    a_first_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid && o_term_index == '0
                              && o_term_value == ONE_Q30_VAL
                              && o_partial_sum == ONE_Q30_VAL))
        else $error("term 0 missing or wrong after transfer");

    // No result while the multiplier passes are in flight
    a_quiet_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_G || r_state == S_MUL_F) |-> !o_valid)
        else $error("result strobe during multiply passes");

    // The term index never passes the last index of the argument
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COEF) |-> (r_idx <= r_last_idx))
        else $error("term index beyond term count");

endmodule

### verif/sqrt_binomial_series_core_test.sv
// Self-checking testbench for the binomial series square root core.
`timescale 1ns / 1ps

module sqrt_binomial_series_core_test;
    import sbs_pkg::*;

    // Expected series terms, predicted from each argument transfer
    class series_scoreboard;
        typedef struct {
            logic [INDEX_W-1:0]      index;
            logic signed [VAL_W-1:0] term;
            logic signed [VAL_W-1:0] psum;
            logic                    last;
        } t_term_rec;

        t_term_rec       expected_terms[$];
        logic [TC_W-1:0] term_count;
        int              failures;

        function new();
            term_count = TERM_COUNT_RESET;
            failures   = 0;
        endfunction

        function void set_term_count(input logic [TC_W-1:0] value);
            term_count = value;
        endfunction

        function int pending();
            return expected_terms.size();
        endfunction

        // Clamp to the signed 32-bit range
        function longint clamp_q30(input longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Work out every term of the series for one argument
        function void note_argument(input logic [X_W-1:0] x);
            longint    n;
            longint    d;
            longint    term;
            longint    sum;
            longint    coef;
            longint    g;
            t_term_rec rec;
            n    = longint'(term_count);
            d    = longint'(x) - 64'sd65536;
            term = ONE_Q30;
            sum  = ONE_Q30;
            if (n < 1)
                n = 1;
            if (n > MAX_TERMS_DEF)
                n = MAX_TERMS_DEF;
            for (longint i = 0; i < n; i++) begin
                if (i > 0) begin
                    // Division truncates toward zero, the shifts floor
                    coef = ((3 - 2 * i) * ONE_Q30) / (2 * i);
                    g    = (coef * d) >>> 16;
                    term = clamp_q30((term * g) >>> 30);
                    sum  = clamp_q30(sum + term);
                end
                rec.index = i[INDEX_W-1:0];
                rec.term  = term[VAL_W-1:0];
                rec.psum  = sum[VAL_W-1:0];
                rec.last  = (i == n - 1);
                expected_terms.push_back(rec);
            end
        endfunction

        // Compare one result transfer with the oldest expected term
        function void check_term(input logic [INDEX_W-1:0] index,
                                 input logic signed [VAL_W-1:0] term,
                                 input logic signed [VAL_W-1:0] psum,
                                 input logic last);
            t_term_rec rec;
            if (expected_terms.size() == 0) begin
                $error("unexpected result: term_index %0d term_value %0d partial_sum %0d",
                       index, term, psum);
                failures++;
                return;
            end
            rec = expected_terms.pop_front();
            if (index !== rec.index) begin
                $error("term_index: expected %0d, actual %0d", rec.index, index);
                failures++;
            end
            if (term !== rec.term) begin
                $error("term_value: expected %0d, actual %0d", rec.term, term);
                failures++;
            end
            if (psum !== rec.psum) begin
                $error("partial_sum: expected %0d, actual %0d", rec.psum, psum);
                failures++;
            end
            if (last !== rec.last) begin
                $error("last: expected %0b, actual %0b", rec.last, last);
                failures++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [X_W-1:0]          i_x_value = '0;
    logic                    i_cfg_we = 1'b0;
    logic [TC_W-1:0]         i_cfg_data = '0;
    logic                    o_valid;
    logic [INDEX_W-1:0]      o_term_index;
    logic signed [VAL_W-1:0] o_term_value;
    logic signed [VAL_W-1:0] o_partial_sum;
    logic                    o_last;

    series_scoreboard board;

    sqrt_binomial_series_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_x_value     (i_x_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_term_index  (o_term_index),
        .o_term_value  (o_term_value),
        .o_partial_sum (o_partial_sum),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Sample register writes, argument transfers and result transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                board.set_term_count(i_cfg_data);
            if (start && !busy)
                board.note_argument(i_x_value);
            if (o_valid)
                board.check_term(o_term_index, o_term_value, o_partial_sum, o_last);
        end
    end

    // Present one argument and hold it until the transfer; return at the next falling edge
    task automatic send_argument(input logic [X_W-1:0] x);
        start     <= 1'b1;
        i_x_value <= x;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        @(negedge i_clk);
    endtask

    // Drop start for a short burst
    task automatic hold_off();
        int gap;
        gap = $urandom_range(1, 3);
        start <= 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    // Let every expected term arrive and the sequencer settle
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_term_count(input logic [TC_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly uniform arguments, with some near one and some at the edges
    function automatic logic [X_W-1:0] pick_argument();
        logic [X_W-1:0] x;
        case ($urandom_range(0, 9))
            0: begin
                x = X_W'(65536 + $urandom_range(0, 512) - 256);
            end
            1: begin
                case ($urandom_range(0, 5))
                    0: x = '0;
                    1: x = 17'd1;
                    2: x = '1;
                    3: x = 17'h1_FFFE;
                    4: x = 17'h0_FFFF;
                    default: x = 17'h1_0000;
                endcase
            end
            default: begin
                x = X_W'($urandom_range(0, 131071));
            end
        endcase
        return x;
    endfunction

    task automatic run_phase(input logic [TC_W-1:0] count, input int items,
                             input bit allow_idle);
        write_term_count(count);
        for (int k = 0; k < items; k++) begin
            if (allow_idle && $urandom_range(0, 3) == 0)
                hold_off();
            send_argument(pick_argument());
        end
    endtask

    // Stimulus
    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset term count: edges of the range, exactly one, either side of one
        send_argument(17'd0);
        send_argument(17'h1_FFFF);
        send_argument(17'h1_0000);
        send_argument(17'h0_FFFF);
        send_argument(17'h1_0001);
        send_argument(17'd1);
        send_argument(17'h0_8000);

        // Zero term count acts as one; arguments back to back
        write_term_count(6'd0);
        send_argument(17'd0);
        send_argument(17'h1_FFFF);
        send_argument(17'h1_0000);

        // Full series, including argument zero
        write_term_count(6'd32);
        send_argument(17'd0);
        send_argument(17'h1_FFFF);
        send_argument(17'd1);

        // Counts above the maximum clamp to it
        write_term_count(6'd63);
        send_argument(17'h1_8000);
        write_term_count(6'd33);
        send_argument(17'h1_3039);

        write_term_count(6'd2);
        send_argument(17'd0);
        send_argument(17'h1_FFFF);

        // Random phases; the last one runs without idling
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: run_phase(6'd1, 25, 1'b1);
                1: run_phase(6'd32, 25, 1'b1);
                2: run_phase(6'd5, 25, 1'b1);
                default: run_phase(TC_W'($urandom_range(0, 63)), 25, p != 7);
            endcase
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (board.failures == 0)
            $display("PASS sqrt_binomial_series_core");
        else
            $display("FAIL sqrt_binomial_series_core");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("FAIL sqrt_binomial_series_core");
        $finish;
    end

endmodule
